// ===== rtl/vlst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlst_pkg: shared types and constants of the segment timing unit
// Field layout of the stream words, command and result codes, fixed-point
// constants and the divider request/response structs.
// ----------------------------------------------------------------------------
package vlst_pkg;

  // sizing defaults
  localparam int JOINTS_DEF        = 14;
  localparam int MAX_WAYPOINTS_DEF = 256;

  // input stream layout
  localparam int JOINT_W     = 4;
  localparam int VALUE_W     = 32;
  localparam int RIDX_W      = 8;
  localparam int JOINT_LSB   = 0;
  localparam int VALUE_LSB   = JOINT_LSB + JOINT_W;
  localparam int RIDX_LSB    = VALUE_LSB + VALUE_W;
  localparam int IN_TDATA_W  = 48;
  localparam int MODE_W      = 2;
  localparam int LASTW_BIT   = MODE_W;
  localparam int IN_TUSER_W  = MODE_W + 1;

  // output stream layout
  localparam int WP_W        = 8;
  localparam int TIME_W      = 32;
  localparam int STATUS_W    = 2;
  localparam int KIND_W      = 2;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_USED_W  = WP_W + TIME_W + STATUS_W + 1;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int SCALE_W    = 17;
  localparam int VMAX_W     = 31;
  localparam int CFG_DATA_W = 31;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 17'd65536;
  localparam logic [VMAX_W-1:0]  VMAX_RESET  = 31'd65536;

  localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VEL     = 1'd1;

  // command and result codes
  localparam logic [MODE_W-1:0] MODE_LIMIT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

  localparam logic [KIND_W-1:0] KIND_WAYPOINT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SUMMARY  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READBACK = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TOO_FEW  = 2'd2;

  // timing constants (microseconds and Q16.16)
  localparam logic [TIME_W-1:0] MIN_SEGMENT_US = 32'd2000;
  localparam logic [TIME_W-1:0] MIN_SPEED_Q16  = 32'd655;
  localparam logic [TIME_W-1:0] LIMIT_US       = 32'd60000000;
  localparam logic [TIME_W-1:0] STRETCH_US     = 32'd100000;

  localparam int US_MUL_W      = 20;
  localparam int STRETCH_MUL_W = 17;
  localparam logic [US_MUL_W-1:0]      US_PER_S    = 20'd1000000;
  localparam logic [STRETCH_MUL_W-1:0] STRETCH_MUL = 17'd100000;

  localparam int PROD_W = VMAX_W + SCALE_W;

  // divider geometry
  localparam int DIV_Q_W    = 32;
  localparam int DIV_NUM_W  = VALUE_W + US_MUL_W;
  localparam int SAT_HI_W   = DIV_NUM_W - DIV_Q_W;
  localparam int RB_NUM_W   = TIME_W + STRETCH_MUL_W;
  localparam int RB_PAD_W   = DIV_NUM_W - RB_NUM_W;
  localparam int DIV_CNT_W  = $clog2(RB_NUM_W + 1);

  typedef struct packed {
    logic                 start;
    logic                 sat_mode;  // quotient saturates instead of wrapping
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_Q_W-1:0]   den;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DIV_Q_W-1:0] quo;
  } div_rsp_t;

endpackage

// ===== rtl/velocity_limited_segment_timing_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// velocity_limited_segment_timing_unit: joint-space path segment timing
// Channel   Dir  Content
// s_axis    in   tdata: joint_index, value, read_index; tuser: mode,
//                last_waypoint; tlast: last_joint
// m_axis    out  tdata: waypoint_number, time_us, status, stretched;
//                tuser: kind; tlast: last
// cfg       in   write enable, register index, write data
//
// A position sample passes the limit, previous, speed and divider states;
// the 32-step divider turns a joint step into microseconds. The first
// waypoint's samples and limit loads are taken in the idle state. Closing
// a waypoint passes a close state, the path summary a summary state. A
// read-back of a stretched total adds a 49-step division. Reset clears
// the registers only; the joint and timestamp memories need no clearing
// pass. A stalled output holds its result while the next item is taken in.
// ----------------------------------------------------------------------------
module velocity_limited_segment_timing_unit #(
  parameter int JOINTS        = vlst_pkg::JOINTS_DEF,
  parameter int MAX_WAYPOINTS = vlst_pkg::MAX_WAYPOINTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // fields from bit 0: joint_index[3:0], value[35:4], read_index[43:36]
  input  logic [vlst_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // fields from bit 0: mode[1:0], last_waypoint[2]
  input  logic [vlst_pkg::IN_TUSER_W-1:0]   s_axis_tuser_i,
  input  logic                              s_axis_tlast_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // fields from bit 0: waypoint_number[7:0], time_us[39:8], status[41:40],
  // stretched[42]
  output logic [vlst_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  // fields from bit 0: kind[1:0]
  output logic [vlst_pkg::KIND_W-1:0]       m_axis_tuser_o,
  output logic                              m_axis_tlast_o,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  input  logic                              cfg_we_i,
  input  logic [vlst_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [vlst_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int JW   = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int JAW  = JW + 1;
  localparam int TAW  = $clog2(MAX_WAYPOINTS);
  localparam int CW   = $clog2(MAX_WAYPOINTS + 1);
  localparam int TW   = vlst_pkg::TIME_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LIM, ST_PREV, ST_SPEED, ST_DIV, ST_DIVW, ST_CLOSE, ST_SUM,
    ST_RD, ST_RD_MUL, ST_RD_DIV, ST_RD_DIVW, ST_RD_EMIT
  } state_e;

  state_e state_q;

  // configuration
  logic [vlst_pkg::SCALE_W-1:0] scale_q;
  logic [vlst_pkg::VMAX_W-1:0]  vmax_q;

  // item fields
  logic [vlst_pkg::JOINT_W-1:0] in_joint;
  logic [vlst_pkg::VALUE_W-1:0] in_value;
  logic [vlst_pkg::RIDX_W-1:0]  in_ridx;
  logic [vlst_pkg::MODE_W-1:0]  in_mode;
  logic                         s_accept;
  logic                         in_jvalid;

  logic [vlst_pkg::JOINT_W-1:0] joint_q;
  logic [vlst_pkg::VALUE_W-1:0] value_q;
  logic [vlst_pkg::RIDX_W-1:0]  ridx_q;
  logic                         ridx_ok_q;
  logic                         lastj_q;
  logic                         lastw_q;

  // path state
  logic [TW-1:0]                seg_max_q;
  logic [TW-1:0]                run_q;
  logic [TW-1:0]                total_q;
  logic [CW-1:0]                count_q;
  logic                         room;

  // datapath
  logic [vlst_pkg::VMAX_W-1:0]    m_q;
  logic                           m_pos_q;
  logic [vlst_pkg::PROD_W-1:0]    prod_q;
  logic [vlst_pkg::VALUE_W-1:0]   step_q;
  logic [TW-1:0]                  speed_q;
  logic [vlst_pkg::DIV_NUM_W-1:0] num_q;
  logic [TW-1:0]                  res_q;

  logic signed [vlst_pkg::VALUE_W-1:0] lim_s;
  logic signed [vlst_pkg::VALUE_W-1:0] cap_s;
  logic signed [vlst_pkg::VALUE_W-1:0] m_s;
  logic [vlst_pkg::VALUE_W:0]          diff;
  logic [vlst_pkg::VALUE_W-1:0]        step_d;
  logic [TW-1:0]                       scaled;
  logic [TW:0]                         run_sum;
  logic [TW-1:0]                       run_new;
  logic [TW-1:0]                       total_new;
  logic [vlst_pkg::STATUS_W-1:0]       sum_status;
  logic                                rb_str;

  // memories
  logic            ja_we;
  logic [JAW-1:0]  ja_waddr;
  logic [31:0]     ja_wdata;
  logic [JAW-1:0]  ja_raddr;
  logic [31:0]     ja_rdata;
  logic            ts_we;
  logic [TAW-1:0]  ts_raddr;
  logic [TW-1:0]   ts_rdata;

  vlst_pkg::div_req_t div_req;
  vlst_pkg::div_rsp_t div_rsp;

  // output register
  logic                           out_free;
  logic                           emit;
  logic [vlst_pkg::KIND_W-1:0]    emit_kind;
  logic [vlst_pkg::WP_W-1:0]      emit_wp;
  logic [TW-1:0]                  emit_time;
  logic [vlst_pkg::STATUS_W-1:0]  emit_status;
  logic                           emit_str;
  logic                           emit_last;
  logic                           m_valid_q;
  logic [vlst_pkg::OUT_TDATA_W-1:0] m_data_q;
  logic [vlst_pkg::KIND_W-1:0]    m_kind_q;
  logic                           m_last_q;

  assign in_joint = s_axis_tdata_i[vlst_pkg::JOINT_LSB +: vlst_pkg::JOINT_W];
  assign in_value = s_axis_tdata_i[vlst_pkg::VALUE_LSB +: vlst_pkg::VALUE_W];
  assign in_ridx  = s_axis_tdata_i[vlst_pkg::RIDX_LSB +: vlst_pkg::RIDX_W];
  assign in_mode  = s_axis_tuser_i[vlst_pkg::MODE_W-1:0];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign in_jvalid       = ({1'b0, in_joint} < (vlst_pkg::JOINT_W + 1)'(JOINTS));
  assign room            = (count_q < CW'(MAX_WAYPOINTS));
  assign out_free        = !m_valid_q || m_axis_tready_i;

  // effective speed path
  assign lim_s  = $signed(ja_rdata);
  assign cap_s  = $signed({1'b0, vmax_q});
  assign m_s    = (lim_s < cap_s) ? lim_s : cap_s;
  assign diff   = {value_q[vlst_pkg::VALUE_W-1], value_q}
                - {ja_rdata[vlst_pkg::VALUE_W-1], ja_rdata};
  assign step_d = diff[vlst_pkg::VALUE_W] ? vlst_pkg::VALUE_W'(-diff)
                                          : diff[vlst_pkg::VALUE_W-1:0];
  assign scaled = prod_q[vlst_pkg::PROD_W-1:16];

  // accumulate with saturation
  assign run_sum = {1'b0, run_q} + {1'b0, seg_max_q};
  assign run_new = (count_q == '0) ? run_q : (run_sum[TW] ? '1 : run_sum[TW-1:0]);

  assign total_new  = (count_q >= CW'(2)) ? run_q : '0;
  assign sum_status = (count_q < CW'(2))               ? vlst_pkg::STATUS_TOO_FEW :
                      (total_new > vlst_pkg::LIMIT_US) ? vlst_pkg::STATUS_TOO_LONG :
                                                         vlst_pkg::STATUS_OK;
  assign rb_str     = (total_q != '0) && (total_q < vlst_pkg::STRETCH_US);

  // joint memory: limits in the lower half, previous positions in the upper
  always_comb begin
    ja_we    = 1'b0;
    ja_waddr = {1'b1, joint_q[JW-1:0]};
    ja_wdata = value_q;
    ja_raddr = {1'b0, in_joint[JW-1:0]};
    if (s_accept && in_jvalid) begin
      if (in_mode == vlst_pkg::MODE_LIMIT) begin
        ja_we    = 1'b1;
        ja_waddr = {1'b0, in_joint[JW-1:0]};
        ja_wdata = in_value;
      end else if (in_mode == vlst_pkg::MODE_SAMPLE && room && count_q == '0) begin
        ja_we    = 1'b1;
        ja_waddr = {1'b1, in_joint[JW-1:0]};
        ja_wdata = in_value;
      end
    end
    if (state_q == ST_LIM) begin
      ja_raddr = {1'b1, joint_q[JW-1:0]};
    end
    if (state_q == ST_PREV) begin
      ja_we = 1'b1;
    end
  end

  assign ts_we    = (state_q == ST_CLOSE) && out_free && room;
  assign ts_raddr = in_ridx[TAW-1:0];

  vlst_ram #(
    .WIDTH (32),
    .DEPTH (2 ** JAW)
  ) u_joint_ram (
    .clk_i   (clk_i),
    .we_i    (ja_we),
    .waddr_i (ja_waddr),
    .wdata_i (ja_wdata),
    .raddr_i (ja_raddr),
    .rdata_o (ja_rdata)
  );

  vlst_ram #(
    .WIDTH (TW),
    .DEPTH (MAX_WAYPOINTS)
  ) u_ts_ram (
    .clk_i   (clk_i),
    .we_i    (ts_we),
    .waddr_i (count_q[TAW-1:0]),
    .wdata_i (run_new),
    .raddr_i (ts_raddr),
    .rdata_o (ts_rdata)
  );

  assign div_req.start    = (state_q == ST_DIV) || (state_q == ST_RD_DIV);
  assign div_req.sat_mode = (state_q == ST_DIV);
  assign div_req.num      = num_q;
  assign div_req.den      = (state_q == ST_DIV) ? speed_q : total_q;

  vlst_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // result selection
  always_comb begin
    emit        = 1'b0;
    emit_kind   = vlst_pkg::KIND_WAYPOINT;
    emit_wp     = vlst_pkg::WP_W'(count_q);
    emit_time   = run_new;
    emit_status = vlst_pkg::STATUS_OK;
    emit_str    = 1'b0;
    emit_last   = !lastw_q;
    case (state_q)
      ST_CLOSE: begin
        emit = out_free && room;
      end
      ST_SUM: begin
        emit        = out_free;
        emit_kind   = vlst_pkg::KIND_SUMMARY;
        emit_wp     = (count_q == '0) ? '0 : vlst_pkg::WP_W'(count_q - 1'b1);
        emit_time   = total_new;
        emit_status = sum_status;
        emit_str    = (total_new != '0) && (total_new < vlst_pkg::STRETCH_US);
        emit_last   = 1'b1;
      end
      ST_RD_EMIT: begin
        emit      = out_free;
        emit_kind = vlst_pkg::KIND_READBACK;
        emit_wp   = ridx_q;
        emit_time = res_q;
        emit_str  = rb_str;
        emit_last = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      scale_q   <= vlst_pkg::SCALE_RESET;
      vmax_q    <= vlst_pkg::VMAX_RESET;
      seg_max_q <= vlst_pkg::MIN_SEGMENT_US;
      run_q     <= '0;
      total_q   <= '0;
      count_q   <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_kind_q  <= '0;
      m_last_q  <= 1'b0;
      joint_q   <= '0;
      value_q   <= '0;
      ridx_q    <= '0;
      ridx_ok_q <= 1'b0;
      lastj_q   <= 1'b0;
      lastw_q   <= 1'b0;
      m_q       <= '0;
      m_pos_q   <= 1'b0;
      prod_q    <= '0;
      step_q    <= '0;
      speed_q   <= '0;
      num_q     <= '0;
      res_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          vlst_pkg::REG_SPEED_SCALE: scale_q <= cfg_wdata_i[vlst_pkg::SCALE_W-1:0];
          vlst_pkg::REG_MAX_VEL:     vmax_q  <= cfg_wdata_i[vlst_pkg::VMAX_W-1:0];
          default:                   vmax_q  <= vmax_q;
        endcase
      end

      // output register: load a new result or drop the taken one
      if (emit) begin
        m_valid_q <= 1'b1;
        m_data_q  <= {{(vlst_pkg::OUT_TDATA_W - vlst_pkg::OUT_USED_W){1'b0}},
                      emit_str, emit_status, emit_time, emit_wp};
        m_kind_q  <= emit_kind;
        m_last_q  <= emit_last;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (s_accept) begin
            joint_q   <= in_joint;
            value_q   <= in_value;
            ridx_q    <= in_ridx;
            ridx_ok_q <= ({1'b0, in_ridx} < (vlst_pkg::RIDX_W + 1)'(MAX_WAYPOINTS));
            lastj_q   <= s_axis_tlast_i;
            lastw_q   <= s_axis_tuser_i[vlst_pkg::LASTW_BIT];
            unique case (in_mode)
              vlst_pkg::MODE_SAMPLE: begin
                if (room && in_jvalid && count_q != '0) begin
                  state_q <= ST_LIM;
                end else if (s_axis_tlast_i) begin
                  state_q <= ST_CLOSE;
                end
              end
              vlst_pkg::MODE_READ: state_q <= ST_RD;
              default:             state_q <= ST_IDLE;
            endcase
          end
        end
        ST_LIM: begin
          m_q     <= m_s[vlst_pkg::VMAX_W-1:0];
          m_pos_q <= !m_s[vlst_pkg::VALUE_W-1] && (m_s != '0);
          state_q <= ST_PREV;
        end
        ST_PREV: begin
          prod_q  <= vlst_pkg::PROD_W'(m_q) * vlst_pkg::PROD_W'(scale_q);
          step_q  <= step_d;
          state_q <= ST_SPEED;
        end
        ST_SPEED: begin
          speed_q <= (m_pos_q && scaled > vlst_pkg::MIN_SPEED_Q16) ? scaled
                                                                 : vlst_pkg::MIN_SPEED_Q16;
          num_q   <= vlst_pkg::DIV_NUM_W'(step_q) * vlst_pkg::DIV_NUM_W'(vlst_pkg::US_PER_S);
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          state_q <= ST_DIVW;
        end
        ST_DIVW: begin
          if (div_rsp.done) begin
            if (div_rsp.quo > seg_max_q) begin
              seg_max_q <= div_rsp.quo;
            end
            state_q <= lastj_q ? ST_CLOSE : ST_IDLE;
          end
        end
        ST_CLOSE: begin
          if (out_free) begin
            if (room) begin
              run_q     <= run_new;
              count_q   <= count_q + 1'b1;
              seg_max_q <= vlst_pkg::MIN_SEGMENT_US;
            end
            state_q <= lastw_q ? ST_SUM : ST_IDLE;
          end
        end
        ST_SUM: begin
          if (out_free) begin
            total_q   <= total_new;
            count_q   <= '0;
            run_q     <= '0;
            seg_max_q <= vlst_pkg::MIN_SEGMENT_US;
            state_q   <= ST_IDLE;
          end
        end
        ST_RD: begin
          res_q   <= ridx_ok_q ? ts_rdata : '0;
          state_q <= ST_RD_MUL;
        end
        ST_RD_MUL: begin
          if (rb_str) begin
            num_q   <= vlst_pkg::DIV_NUM_W'(res_q)
                     * vlst_pkg::DIV_NUM_W'(vlst_pkg::STRETCH_MUL);
            state_q <= ST_RD_DIV;
          end else begin
            state_q <= ST_RD_EMIT;
          end
        end
        ST_RD_DIV: begin
          state_q <= ST_RD_DIVW;
        end
        ST_RD_DIVW: begin
          if (div_rsp.done) begin
            res_q   <= div_rsp.quo;
            state_q <= ST_RD_EMIT;
          end
        end
        ST_RD_EMIT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_kind_q;
  assign m_axis_tlast_o  = m_last_q;

  a_idle_div_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !div_rsp.busy)
    else $error("divider busy while taking a new item");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_WAYPOINTS))
    else $error("waypoint count past capacity");

  a_seg_floor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_max_q >= vlst_pkg::MIN_SEGMENT_US)
    else $error("segment time below minimum");

  a_done_waited : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIVW || state_q == ST_RD_DIVW))
    else $error("quotient returned with nobody waiting");

  a_ts_write_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ts_we |=> count_q == $past(count_q) + 1'b1)
    else $error("timestamp written without advancing the waypoint count");

endmodule

// ===== rtl/vlst_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlst_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module vlst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/vlst_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlst_div: radix-2 restoring divider
// Saturating mode: quotient limited to 32 bits, 32 steps. Wrapping mode:
// 49-bit numerator, 49 steps, low 32 quotient bits returned.
// ----------------------------------------------------------------------------
module vlst_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vlst_pkg::div_req_t req_i,
  output vlst_pkg::div_rsp_t rsp_o
);

  logic                               busy_q;
  logic                               done_q;
  logic                               sat_q;
  logic [vlst_pkg::DIV_CNT_W-1:0]     cnt_q;
  logic [vlst_pkg::DIV_Q_W-1:0]       rem_q;
  logic [vlst_pkg::DIV_Q_W-1:0]       rem_d;
  logic [vlst_pkg::DIV_NUM_W-1:0]     sh_q;
  logic [vlst_pkg::DIV_Q_W-1:0]       den_q;
  logic [vlst_pkg::DIV_Q_W:0]         trial;
  logic [vlst_pkg::DIV_Q_W:0]         diff;
  logic                               ge;
  logic [vlst_pkg::DIV_Q_W-1:0]       num_hi;

  assign num_hi = vlst_pkg::DIV_Q_W'(req_i.num[vlst_pkg::DIV_NUM_W-1:vlst_pkg::DIV_Q_W]);

  // one quotient bit per step
  assign trial = {rem_q, sh_q[vlst_pkg::DIV_NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});
  assign rem_d = ge ? diff[vlst_pkg::DIV_Q_W-1:0] : trial[vlst_pkg::DIV_Q_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= req_i.sat_mode ? vlst_pkg::DIV_CNT_W'(vlst_pkg::DIV_Q_W)
                               : vlst_pkg::DIV_CNT_W'(vlst_pkg::RB_NUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == vlst_pkg::DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      den_q <= req_i.den;
      if (req_i.sat_mode) begin
        // upper numerator part at or above the divisor means a quotient past 32 bits
        sat_q <= (num_hi >= req_i.den);
        rem_q <= num_hi;
        sh_q  <= {req_i.num[vlst_pkg::DIV_Q_W-1:0], {vlst_pkg::SAT_HI_W{1'b0}}};
      end else begin
        sat_q <= 1'b0;
        rem_q <= '0;
        sh_q  <= {req_i.num[vlst_pkg::RB_NUM_W-1:0], {vlst_pkg::RB_PAD_W{1'b0}}};
      end
    end else if (busy_q) begin
      rem_q <= rem_d;
      sh_q  <= {sh_q[vlst_pkg::DIV_NUM_W-2:0], ge};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = sat_q ? '1 : sh_q[vlst_pkg::DIV_Q_W-1:0];

endmodule
